// ===== design/cfr_pkg.sv =====
// Shared types and constants of the command frame receiver.
// No dependencies; every design file of the block refers to it by scoped names, the testbench imports it.

package cfr_pkg;

   localparam int DATA_W        = 8;
   localparam int PAYLOAD_W     = 48;
   localparam int PAYLOAD_LANES = PAYLOAD_W / DATA_W;
   localparam int PAYLOAD_BYTES = 6;
   localparam int CNT_W         = 3;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(PAYLOAD_BYTES - 1);

   // result buffer occupancy when both entries are held
   localparam logic [1:0] BUF_FULL = 2'd2;

   // csr register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_VELOCITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_PID      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_PARAMS   = 3'd4;

   localparam logic [DATA_W-1:0] HEADER_FIRST_RST  = 8'hAA;
   localparam logic [DATA_W-1:0] HEADER_SECOND_RST = 8'h55;
   localparam logic [DATA_W-1:0] TYPE_VELOCITY_RST = 8'h01;
   localparam logic [DATA_W-1:0] TYPE_PID_RST      = 8'h02;
   localparam logic [DATA_W-1:0] TYPE_PARAMS_RST   = 8'h03;

   typedef struct packed {
      logic [DATA_W-1:0] header_first;
      logic [DATA_W-1:0] header_second;
      logic [DATA_W-1:0] type_velocity_code;
      logic [DATA_W-1:0] type_pid_code;
      logic [DATA_W-1:0] type_params_code;
   } cfr_cfg_type;

   typedef struct packed {
      logic                 frame_kind;
      logic [DATA_W-1:0]    size_byte;
      logic [PAYLOAD_W-1:0] payload;
   } cfr_result_type;

   typedef enum logic [5:0] {
      PH_HEAD1   = 6'b000001,
      PH_HEAD2   = 6'b000010,
      PH_SIZE    = 6'b000100,
      PH_TYPE    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_CHECK   = 6'b100000
   } cfr_phase_type;

   typedef enum logic [1:0] {
      KIND_VEL    = 2'd0,
      KIND_PID    = 2'd1,
      KIND_PARAMS = 2'd2
   } cfr_kind_type;

endpackage

// ===== design/cfr_ifs.sv =====
// Valid/ready channel interfaces of the command frame receiver.
// Depends on cfr_pkg for field widths.

interface cfr_req_if;
   logic                      valid;
   logic                      ready;
   logic [cfr_pkg::DATA_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          frame_kind;
   logic [cfr_pkg::DATA_W-1:0]    size_byte;
   logic [cfr_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, output frame_kind, output size_byte, output payload,
                   input ready);
   modport sink   (input valid, input frame_kind, input size_byte, input payload,
                   output ready);
endinterface

// ===== design/command_frame_receiver.sv =====
// Top level of the command frame receiver: csr registers, parser and result buffer.
// Depends on cfr_pkg, cfr_ifs, cfr_parser and cfr_out_buf.
//
//   channel    dir   beat payload                          handshake
//   req_chan   in    rx_byte (8)                           valid/ready
//   rsp_chan   out   frame_kind (1), size_byte (8),        valid/ready
//                    payload (48)
//   csr_*      in    csr_index (3), csr_wdata (8)          csr_we, no back-pressure
//
// One received byte per cycle while req_chan.ready is high; the parser decides each byte in the cycle it is taken.
// A result beat is visible on rsp_chan the cycle after the checksum byte is taken, if the buffer was empty.
// Two result beats are buffered: req_chan.ready drops only when both are held.
// Synchronous active-high reset returns to the header hunt, empties the buffer and restores the csr reset values.

module command_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   cfr_req_if.sink                       req_chan,
   cfr_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [cfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfr_pkg::DATA_W-1:0]    csr_wdata
);

   cfr_pkg::cfr_cfg_type     cfg_ff, cfg_in;
   cfr_pkg::cfr_result_type  res;
   cfr_pkg::cfr_result_type  out_data;
   logic                     res_valid;
   logic                     in_accept;
   logic                     space_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cfr_pkg::CSR_HEADER_FIRST:  cfg_in.header_first       = csr_wdata;
            cfr_pkg::CSR_HEADER_SECOND: cfg_in.header_second      = csr_wdata;
            cfr_pkg::CSR_TYPE_VELOCITY: cfg_in.type_velocity_code = csr_wdata;
            cfr_pkg::CSR_TYPE_PID:      cfg_in.type_pid_code      = csr_wdata;
            cfr_pkg::CSR_TYPE_PARAMS:   cfg_in.type_params_code   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first       <= cfr_pkg::HEADER_FIRST_RST;
         cfg_ff.header_second      <= cfr_pkg::HEADER_SECOND_RST;
         cfg_ff.type_velocity_code <= cfr_pkg::TYPE_VELOCITY_RST;
         cfg_ff.type_pid_code      <= cfr_pkg::TYPE_PID_RST;
         cfg_ff.type_params_code   <= cfr_pkg::TYPE_PARAMS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = space_ok;
   assign in_accept      = req_chan.valid && space_ok;

   cfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_accept (in_accept),
      .in_byte   (req_chan.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   cfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (in_accept && res_valid),
      .push_data (res),
      .space_ok  (space_ok),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.frame_kind = out_data.frame_kind;
   assign rsp_chan.size_byte  = out_data.size_byte;
   assign rsp_chan.payload    = out_data.payload;

endmodule

// ===== design/cfr_parser.sv =====
// Frame parse state machine: one received byte per accepted beat.
// Depends on cfr_pkg; produces at most one result per beat, combinationally.

module cfr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  cfr_pkg::cfr_cfg_type        cfg,
   input  logic                        in_accept,
   input  logic [cfr_pkg::DATA_W-1:0]  in_byte,
   output logic                        res_valid,
   output cfr_pkg::cfr_result_type     res
);

   cfr_pkg::cfr_phase_type            phase_ff, phase_in;
   cfr_pkg::cfr_kind_type             kind_ff, kind_in;
   logic [cfr_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [cfr_pkg::DATA_W-1:0]        sum_ff, sum_in;
   logic [cfr_pkg::DATA_W-1:0]        size_ff, size_in;
   logic [cfr_pkg::PAYLOAD_W-1:0]     payload_ff, payload_in;
   logic [cfr_pkg::DATA_W-1:0]        sum_add;

   assign sum_add = sum_ff + in_byte;

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      sum_in     = sum_add;
      size_in    = size_ff;
      payload_in = payload_ff;
      res_valid  = 1'b0;
      res.frame_kind = (kind_ff == cfr_pkg::KIND_PID);
      res.size_byte  = size_ff;
      res.payload    = payload_ff;

      case (phase_ff)
         cfr_pkg::PH_HEAD1: begin
            sum_in = in_byte;
            if (in_byte == cfg.header_first) begin
               phase_in = cfr_pkg::PH_HEAD2;
            end
         end
         cfr_pkg::PH_HEAD2: begin
            // a mismatch is not retried as a first header byte
            phase_in = (in_byte == cfg.header_second) ? cfr_pkg::PH_SIZE : cfr_pkg::PH_HEAD1;
         end
         cfr_pkg::PH_SIZE: begin
            size_in  = in_byte;
            phase_in = cfr_pkg::PH_TYPE;
         end
         cfr_pkg::PH_TYPE: begin
            count_in   = '0;
            payload_in = '0;
            phase_in   = cfr_pkg::PH_PAYLOAD;
            // velocity wins over PID, PID over params
            if (in_byte == cfg.type_velocity_code) begin
               kind_in = cfr_pkg::KIND_VEL;
            end else if (in_byte == cfg.type_pid_code) begin
               kind_in = cfr_pkg::KIND_PID;
            end else if (in_byte == cfg.type_params_code) begin
               kind_in = cfr_pkg::KIND_PARAMS;
            end else begin
               phase_in = cfr_pkg::PH_HEAD1;
            end
         end
         cfr_pkg::PH_PAYLOAD: begin
            for (int i = 0; i < cfr_pkg::PAYLOAD_LANES; i++) begin
               if (count_ff == cfr_pkg::CNT_W'(i)) begin
                  payload_in[cfr_pkg::DATA_W*i +: cfr_pkg::DATA_W] = in_byte;
               end
            end
            if (count_ff == cfr_pkg::LAST_COUNT) begin
               // params frames carry no checksum byte
               phase_in = (kind_ff == cfr_pkg::KIND_PARAMS) ? cfr_pkg::PH_HEAD1
                                                            : cfr_pkg::PH_CHECK;
            end else begin
               count_in = count_ff + cfr_pkg::CNT_W'(1);
            end
         end
         cfr_pkg::PH_CHECK: begin
            res_valid = (in_byte == sum_ff);
            phase_in  = cfr_pkg::PH_HEAD1;
         end
         default: begin
            phase_in = cfr_pkg::PH_HEAD1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cfr_pkg::PH_HEAD1;
         kind_ff    <= cfr_pkg::KIND_VEL;
         count_ff   <= '0;
         sum_ff     <= '0;
         size_ff    <= '0;
         payload_ff <= '0;
      end else if (in_accept) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         size_ff    <= size_in;
         payload_ff <= payload_in;
      end
   end

endmodule

// ===== design/cfr_out_buf.sv =====
// Two-entry result buffer between the parser and the result channel.
// Depends on cfr_pkg; space_ok is decoded from the count register alone.

module cfr_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cfr_pkg::cfr_result_type  push_data,
   output logic                     space_ok,
   output logic                     out_valid,
   input  logic                     out_ready,
   output cfr_pkg::cfr_result_type  out_data
);

   logic [1:0]               count_ff, count_in;
   cfr_pkg::cfr_result_type  ent0_ff, ent0_in;
   cfr_pkg::cfr_result_type  ent1_ff, ent1_in;
   logic                     pop;
   logic [1:0]               slot;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = ent0_ff;
   assign space_ok  = (count_ff != cfr_pkg::BUF_FULL);
   assign slot      = count_ff - {1'b0, pop};

   always_comb begin
      ent0_in  = pop ? ent1_ff : ent0_ff;
      ent1_in  = ent1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (push) begin
         if (slot == 2'd0) begin
            ent0_in = push_data;
         end else begin
            ent1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

endmodule

// ===== tb/sv/tb_command_frame_receiver.sv =====
// Testbench for command_frame_receiver: byte stimulus, frame predictor and result checks.
// Depends on cfr_pkg and cfr_ifs from the design, plus the command_frame_receiver top.

module tb_command_frame_receiver;
   import cfr_pkg::*;

   localparam int FRAME_BYTES = PAYLOAD_BYTES + 5;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   // Predicts frames from the accepted byte stream and checks the result beats.
   class frame_scoreboard;
      cfr_cfg_type          regs;
      cfr_phase_type        step;
      logic [CNT_W-1:0]     taken;
      logic [DATA_W-1:0]    run_sum;
      cfr_kind_type         kind;
      logic [DATA_W-1:0]    frame_len;
      logic [PAYLOAD_W-1:0] gathered;
      cfr_result_type       expected_frames[$];
      int                   frames_seen;
      int                   mismatches;

      function new();
         regs = {HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_VELOCITY_RST,
                 TYPE_PID_RST, TYPE_PARAMS_RST};
         frames_seen = 0;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         step = PH_HEAD1;
         taken = '0;
         run_sum = '0;
         kind = KIND_VEL;
         frame_len = '0;
         gathered = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
         case (idx)
            CSR_HEADER_FIRST:  regs.header_first = val;
            CSR_HEADER_SECOND: regs.header_second = val;
            CSR_TYPE_VELOCITY: regs.type_velocity_code = val;
            CSR_TYPE_PID:      regs.type_pid_code = val;
            CSR_TYPE_PARAMS:   regs.type_params_code = val;
            default: ;
         endcase
      endfunction

      function void note_byte(logic [DATA_W-1:0] b);
         cfr_result_type r;
         case (step)
            PH_HEAD1: if (b == regs.header_first) begin
               run_sum = b;
               step = PH_HEAD2;
            end
            PH_HEAD2: if (b == regs.header_second) begin
               run_sum = run_sum + b;
               step = PH_SIZE;
            end else begin
               restart();
            end
            PH_SIZE: begin
               frame_len = b;
               run_sum = run_sum + b;
               step = PH_TYPE;
            end
            PH_TYPE: begin
               run_sum = run_sum + b;
               taken = '0;
               gathered = '0;
               step = PH_PAYLOAD;
               // velocity wins over PID, PID over params
               if (b == regs.type_velocity_code) kind = KIND_VEL;
               else if (b == regs.type_pid_code) kind = KIND_PID;
               else if (b == regs.type_params_code) kind = KIND_PARAMS;
               else restart();
            end
            PH_PAYLOAD: begin
               run_sum = run_sum + b;
               gathered = gathered | (PAYLOAD_W'(b) << (DATA_W * taken));
               if (taken == LAST_COUNT) begin
                  if (kind == KIND_PARAMS) restart();
                  else step = PH_CHECK;
               end else begin
                  taken = taken + CNT_W'(1);
               end
            end
            PH_CHECK: begin
               if (b == run_sum) begin
                  r.frame_kind = (kind == KIND_PID);
                  r.size_byte = frame_len;
                  r.payload = gathered;
                  expected_frames.push_back(r);
               end
               restart();
            end
            default: restart();
         endcase
      endfunction

      function void check_frame(logic fk, logic [DATA_W-1:0] fs, logic [PAYLOAD_W-1:0] pl);
         cfr_result_type e;
         frames_seen++;
         if (expected_frames.size() == 0) begin
            $error("unexpected result beat: frame_kind %0d size_byte 0x%02h payload 0x%012h",
                   fk, fs, pl);
            mismatches++;
            return;
         end
         e = expected_frames.pop_front();
         if (fk !== e.frame_kind) begin
            $error("frame_kind expected %0d actual %0d", e.frame_kind, fk);
            mismatches++;
         end
         if (fs !== e.size_byte) begin
            $error("size_byte expected 0x%02h actual 0x%02h", e.size_byte, fs);
            mismatches++;
         end
         if (pl !== e.payload) begin
            $error("payload expected 0x%012h actual 0x%012h", e.payload, pl);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wdata;

   cfr_req_if req_if();
   cfr_rsp_if rsp_if();

   command_frame_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_scoreboard sb = new();
   cfr_cfg_type link_cfg;     // settings the byte generator builds frames for
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_left;
   int bytes_sent;
   int settings_used;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls plus the long hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever @(negedge clock) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_byte(req_if.rx_byte);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_frame(rsp_if.frame_kind, rsp_if.size_byte, rsp_if.payload);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
         $display("tb_command_frame_receiver failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [DATA_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Only called with nothing in flight; the pause covers the result buffer.
   task automatic apply_settings(input cfr_cfg_type c);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_HEADER_FIRST, c.header_first);
      write_reg(CSR_HEADER_SECOND, c.header_second);
      write_reg(CSR_TYPE_VELOCITY, c.type_velocity_code);
      write_reg(CSR_TYPE_PID, c.type_pid_code);
      write_reg(CSR_TYPE_PARAMS, c.type_params_code);
      @(negedge clock);
      csr_we <= 1'b0;
      link_cfg = c;
      settings_used++;
   endtask

   function automatic bit has_checksum(logic [DATA_W-1:0] code);
      return code == link_cfg.type_velocity_code || code == link_cfg.type_pid_code;
   endfunction

   // Sends up to cut bytes of a frame; sum_err nonzero corrupts the checksum byte.
   task automatic send_frame(input logic [DATA_W-1:0] code, input logic [DATA_W-1:0] len,
                             input logic [PAYLOAD_W-1:0] body,
                             input logic [DATA_W-1:0] sum_err, input int cut);
      logic [DATA_W-1:0] seq [FRAME_BYTES];
      logic [DATA_W-1:0] acc;
      int n;
      seq[0] = link_cfg.header_first;
      seq[1] = link_cfg.header_second;
      seq[2] = len;
      seq[3] = code;
      for (int i = 0; i < PAYLOAD_BYTES; i++) seq[4+i] = body[DATA_W*i +: DATA_W];
      acc = '0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) acc = acc + seq[i];
      seq[FRAME_BYTES-1] = acc + sum_err;
      n = has_checksum(code) ? FRAME_BYTES : FRAME_BYTES - 1;
      if (cut < n) n = cut;
      for (int i = 0; i < n; i++) send_byte(seq[i]);
   endtask

   function automatic logic [PAYLOAD_W-1:0] random_body();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   task automatic send_good_frame();
      logic [DATA_W-1:0] code;
      code = $urandom_range(1) ? link_cfg.type_pid_code : link_cfg.type_velocity_code;
      send_frame(code, 8'($urandom), random_body(), '0, FRAME_BYTES);
   endtask

   task automatic send_random_item();
      logic [DATA_W-1:0] b;
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         send_good_frame();
      end else if (pick < 58) begin
         send_frame(link_cfg.type_params_code, 8'($urandom), random_body(), '0, FRAME_BYTES);
      end else if (pick < 66) begin
         send_frame(link_cfg.type_velocity_code, 8'($urandom), random_body(),
                    8'($urandom_range(255, 1)), FRAME_BYTES);
      end else if (pick < 73) begin
         do b = 8'($urandom); while (b == link_cfg.header_second);
         send_byte(link_cfg.header_first);
         send_byte(b);
      end else if (pick < 80) begin
         do b = 8'($urandom);
         while (b == link_cfg.type_velocity_code || b == link_cfg.type_pid_code ||
                b == link_cfg.type_params_code);
         send_frame(b, 8'($urandom), '0, '0, 4);
      end else if (pick < 88) begin
         // frame cut short; the next one lands inside it
         send_frame(link_cfg.type_pid_code, 8'($urandom), random_body(), '0,
                    $urandom_range(FRAME_BYTES - 1, 1));
      end else begin
         repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
   endtask

   task automatic run_random(input int upto);
      while (bytes_sent < upto) send_random_item();
   endtask

   initial begin
      cfr_cfg_type c;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.rx_byte = '0;
      hold_left = 0;
      bytes_sent = 0;
      settings_used = 1;
      quiet_cycles = 0;
      req_idle_pct = 29;
      rsp_idle_pct = 66;
      link_cfg = {HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_VELOCITY_RST,
                  TYPE_PID_RST, TYPE_PARAMS_RST};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed frames at reset settings
      send_frame(link_cfg.type_velocity_code, 8'h00, '0, '0, FRAME_BYTES);
      send_frame(link_cfg.type_pid_code, 8'hFF, '1, '0, FRAME_BYTES);
      send_byte(link_cfg.header_first);
      send_byte(~link_cfg.header_second);   // equals first header, must not restart a frame
      send_frame(8'hFF, 8'h10, '0, '0, 4);
      send_frame(link_cfg.type_params_code, 8'h06, 48'h0123456789AB, '0, FRAME_BYTES);
      send_frame(link_cfg.type_velocity_code, 8'h06, 48'hFEDCBA987654, 8'h01, FRAME_BYTES);
      run_random(600);
      stop_sending();

      req_idle_pct = 66;
      rsp_idle_pct = 29;
      c = {8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80};
      apply_settings(c);
      run_random(1200);
      stop_sending();

      // all type codes equal: velocity must win
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      c = {8'hFF, 8'h00, 8'h7E, 8'h7E, 8'h7E};
      apply_settings(c);
      run_random(1300);
      hold_left = HOLD_CYCLES;
      repeat (8) send_good_frame();
      run_random(1500);
      stop_sending();

      // random headers, PID and params sharing a code
      c.header_first = 8'($urandom);
      c.header_second = 8'($urandom);
      c.type_velocity_code = 8'($urandom);
      do c.type_pid_code = 8'($urandom); while (c.type_pid_code == c.type_velocity_code);
      c.type_params_code = c.type_pid_code;
      apply_settings(c);
      send_frame(c.type_pid_code, 8'h5A, random_body(), '0, FRAME_BYTES);
      run_random(1850);
      stop_sending();

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d bytes under %0d register settings, checked %0d frames",
               bytes_sent, settings_used, sb.frames_seen);
      $display("directed cases, long result stall and mixed idling included");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_command_frame_receiver passed");
      else
         $display("tb_command_frame_receiver failed");
      $finish;
   end

endmodule
